[design/particle_euler_update_macros.svh]
// ----------------------------------------------------------------------------
// particle_euler_update_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_EULER_UPDATE_MACROS_SVH
`define PARTICLE_EULER_UPDATE_MACROS_SVH

// Concurrent property on the block clock, quiet during reset.
`define PEL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("particle_euler_update check failed");

// Property that must hold whenever a result item is on offer.
`define PEL_ASSERT_OUT(lbl, expr) \
    `PEL_ASSERT(lbl, m_valid |-> (expr))

`endif

[design/pel_pkg.sv]
// ----------------------------------------------------------------------------
// pel_pkg
// Types, constants and the sine table builder for the particle update.
// ----------------------------------------------------------------------------
`default_nettype none

package pel_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [1:0] KIND_TRAIL = 2'd0;
    localparam logic [1:0] KIND_RAIN  = 2'd1;
    localparam logic [1:0] KIND_SNOW  = 2'd2;

    localparam logic [1:0] REG_KIND    = 2'd0;
    localparam logic [1:0] REG_GRAVITY = 2'd1;
    localparam logic [1:0] REG_RECIP   = 2'd2;
    localparam logic [1:0] REG_BASE    = 2'd3;

    // 0.6 and 0.8 in Q16.16
    localparam longint ALPHA_K = (6 * (64'sd1 <<< FRAC_BITS) + 5) / 10;
    localparam longint GROW_K  = (8 * (64'sd1 <<< FRAC_BITS) + 5) / 10;

    // turns per unit of life for the 3x and 2.5x angles, Q0.32 scaled
    localparam longint TURN_K3  = 64'sd2050695827;
    localparam longint TURN_K25 = 64'sd1708913189;

    localparam longint Q30_ONE     = 64'sd1 <<< 30;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] gravity;
        logic [24:0]        recip;
        logic [30:0]        base;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] life;
        logic [30:0]        size;
        logic [15:0]        alpha;
        logic [15:0]        dt;
        logic               alive;
    } rec_t;

    // Two truncating Q2.30 products in turn: t * x * x.
    function automatic longint sq_scale(longint t, longint x);
        longint u;
        u = t * x / Q30_ONE;
        return u * x / Q30_ONE;
    endfunction

    // Nine-term Taylor series of sin(x), x in Q2.30, truncating each step.
    function automatic longint sine_taylor(longint x);
        longint term;
        longint sum;
        term = x;
        sum  = x;
        term = -(sq_scale(term, x) / 64'sd6);
        sum  = sum + term;
        term = -(sq_scale(term, x) / 64'sd20);
        sum  = sum + term;
        term = -(sq_scale(term, x) / 64'sd42);
        sum  = sum + term;
        term = -(sq_scale(term, x) / 64'sd72);
        sum  = sum + term;
        term = -(sq_scale(term, x) / 64'sd110);
        sum  = sum + term;
        term = -(sq_scale(term, x) / 64'sd156);
        sum  = sum + term;
        term = -(sq_scale(term, x) / 64'sd210);
        sum  = sum + term;
        term = -(sq_scale(term, x) / 64'sd272);
        sum  = sum + term;
        if (sum < 0) sum = 0;
        if (sum > Q30_ONE) sum = Q30_ONE;
        return sum;
    endfunction

endpackage

`default_nettype wire

[design/pel_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pel_cfg_regs
// Configuration register file, written over a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pel_cfg_regs (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output pel_pkg::cfg_t           cfg
);
    import pel_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kind    <= KIND_TRAIL;
            cfg_reg.gravity <= -32'sd19661;
            cfg_reg.recip   <= 25'd13107;
            cfg_reg.base    <= 31'd983040;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KIND:    cfg_reg.kind    <= cfg_data[1:0];
                REG_GRAVITY: cfg_reg.gravity <= $signed(cfg_data);
                REG_RECIP:   cfg_reg.recip   <= cfg_data[24:0];
                REG_BASE:    cfg_reg.base    <= cfg_data[30:0];
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/pel_sine_unit.sv]
// ----------------------------------------------------------------------------
// pel_sine_unit
// Two-lane quarter-wave sine lookup, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pel_sine_unit #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [31:0]        phase_a,
    input  wire logic [31:0]        phase_b,
    output logic signed [31:0]      val_a,
    output logic signed [31:0]      val_b
);
    import pel_pkg::*;

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = 30 + IDX_W;

    logic [30:0] rom [0:SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam longint X = HALF_PI_Q30 * gi / SINE_TABLE_DEPTH;
        localparam longint S = sine_taylor(X);
        assign rom[gi] = 31'(S);
    end

    logic [PROD_W-1:0]  prod_reg [2];
    logic [1:0]         quad_reg [2];
    logic signed [31:0] val_reg  [2];
    logic [31:0]        phase    [2];
    logic [PROD_W-1:0]  prod_next [2];
    logic signed [31:0] val_next  [2];

    assign phase[0] = phase_a;
    assign phase[1] = phase_b;

    always_comb begin
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] addr;
        logic [30:0]      mag;
        for (int l = 0; l < 2; l++) begin
            prod_next[l] = PROD_W'(phase[l][29:0]) * PROD_W'(SINE_TABLE_DEPTH);
            idx  = prod_reg[l][PROD_W-1:30];
            // odd quadrants read the table backwards
            addr = quad_reg[l][0] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
            mag  = rom[addr];
            val_next[l] = quad_reg[l][1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                prod_reg[l] <= prod_next[l];
                quad_reg[l] <= phase[l][31:30];
                val_reg[l]  <= val_next[l];
            end
        end
    end

    assign val_a = val_reg[0];
    assign val_b = val_reg[1];

endmodule

`default_nettype wire

[design/particle_euler_update.sv]
// ----------------------------------------------------------------------------
// particle_euler_update
// One explicit Euler step of a particle record, six-stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one particle item per cycle and returns the advanced items
// in order; sustained rate is one item per clock while m_ready stays high.
// The pipeline depth is set by the chain of dependent products:
// gravity into vertical velocity, that velocity times the step into position,
// the life ratio into alpha and growth, and the two-stage sine table lookup
// feeding the snow sway. All stages advance together on one enable, so a stall
// at the output holds every stage and loses nothing. Configuration writes are
// taken at any time (cfg_ready is tied high) but must only be issued while the
// pipeline is empty. Q16.16 throughout; positions and velocities wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_euler_update #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    // input items
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_pos_x,
    input  wire logic signed [31:0] s_pos_y,
    input  wire logic signed [31:0] s_pos_z,
    input  wire logic signed [31:0] s_vel_x,
    input  wire logic signed [31:0] s_vel_y,
    input  wire logic signed [31:0] s_vel_z,
    input  wire logic signed [31:0] s_life_left,
    input  wire logic [30:0]        s_size_now,
    input  wire logic [15:0]        s_alpha_now,
    input  wire logic [15:0]        s_step_time,
    // result items
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_new_pos_x,
    output logic signed [31:0]      m_new_pos_y,
    output logic signed [31:0]      m_new_pos_z,
    output logic signed [31:0]      m_new_vel_x,
    output logic signed [31:0]      m_new_vel_y,
    output logic signed [31:0]      m_new_vel_z,
    output logic signed [31:0]      m_new_life,
    output logic [30:0]             m_new_size,
    output logic [15:0]             m_new_alpha,
    output logic                    m_was_alive
);
    import pel_pkg::*;

    cfg_t cfg;

    pel_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Global stage enable: advance unless the output item is stalled.
    logic en;
    logic [5:0] vld_reg;
    assign en      = !vld_reg[5] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], s_valid};
        end
    end

    rec_t r1_reg, r2_reg, r3_reg, r4_reg, r5_reg, r6_reg;
    rec_t r1_next, r2_next, r3_next, r4_next, r5_next, r6_next;

    // side products per stage
    logic signed [48:0] gdt1_reg, vxdt1_reg, vzdt1_reg;
    logic signed [48:0] gdt1_next, vxdt1_next, vzdt1_next;
    logic signed [56:0] rp2_reg, rp2_next;
    logic signed [63:0] ph3_2_reg, ph25_2_reg, ph3_2_next, ph25_2_next;
    logic signed [48:0] vydt3_reg, vydt3_next;
    logic signed [40:0] ratio3_reg, ratio3_next;
    logic signed [57:0] apr3_reg, apr3_next;
    logic signed [59:0] grow3_reg, grow3_next;
    logic [32:0]        g4_reg, g4_next;
    logic               gzero4_reg, gzero4_next;
    logic [63:0]        sprod5_reg, sprod5_next;
    logic               gzero5_reg;
    logic signed [48:0] sndt5_reg, csdt5_reg, sndt5_next, csdt5_next;

    logic [31:0]        phase_sin, phase_cos;
    logic signed [31:0] sin4, cos4;

    // Stage 1: age the particle, start the gravity and x/z products.
    always_comb begin
        logic signed [16:0] dt_s;
        dt_s = $signed({1'b0, s_step_time});
        r1_next.px    = s_pos_x;
        r1_next.py    = s_pos_y;
        r1_next.pz    = s_pos_z;
        r1_next.vx    = s_vel_x;
        r1_next.vy    = s_vel_y;
        r1_next.vz    = s_vel_z;
        r1_next.size  = s_size_now;
        r1_next.alpha = s_alpha_now;
        r1_next.dt    = s_step_time;
        r1_next.alive = s_life_left > 0;
        r1_next.life  = r1_next.alive ? (s_life_left - 32'(dt_s)) : s_life_left;
        gdt1_next  = 49'(cfg.gravity) * 49'(dt_s);
        vxdt1_next = 49'(s_vel_x) * 49'(dt_s);
        vzdt1_next = 49'(s_vel_z) * 49'(dt_s);
    end

    // Stage 2: apply gravity, move x and z, start ratio and phase products.
    always_comb begin
        r2_next = r1_reg;
        if (r1_reg.alive) begin
            r2_next.vy = r1_reg.vy + 32'(gdt1_reg >>> FRAC_BITS);
            r2_next.px = r1_reg.px + 32'(vxdt1_reg >>> FRAC_BITS);
            r2_next.pz = r1_reg.pz + 32'(vzdt1_reg >>> FRAC_BITS);
        end
        rp2_next    = 57'(r1_reg.life) * 57'($signed({1'b0, cfg.recip}));
        ph3_2_next  = 64'(r1_reg.life) * TURN_K3;
        ph25_2_next = 64'(r1_reg.life) * TURN_K25;
    end

    // Stage 3: y product, alpha and growth products; phases into the table.
    always_comb begin
        logic signed [40:0] ratio;
        ratio       = 41'(rp2_reg >>> FRAC_BITS);
        r3_next     = r2_reg;
        vydt3_next  = 49'(r2_reg.vy) * 49'($signed({1'b0, r2_reg.dt}));
        ratio3_next = ratio;
        apr3_next   = 58'(ratio) * 58'(ALPHA_K);
        grow3_next  = (60'(64'sd1 <<< FRAC_BITS) - 60'(ratio)) * 60'(GROW_K);
    end

    assign phase_sin = ph3_2_reg[47:16];
    assign phase_cos = ph25_2_reg[47:16] + 32'h4000_0000;

    pel_sine_unit #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .aclk    (aclk),
        .en      (en),
        .phase_a (phase_sin),
        .phase_b (phase_cos),
        .val_a   (sin4),
        .val_b   (cos4)
    );

    // Stage 4: move y, clamp alpha, form the growth factor.
    always_comb begin
        logic signed [57:0] a;
        logic signed [59:0] g;
        r4_next = r3_reg;
        if (r3_reg.alive) begin
            r4_next.py = r3_reg.py + 32'(vydt3_reg >>> FRAC_BITS);
        end
        a = (cfg.kind == KIND_TRAIL) ? 58'(ratio3_reg >>> 1) : (apr3_reg >>> FRAC_BITS);
        if (r3_reg.alive) begin
            if (a <= 0) begin
                r4_next.alpha = '0;
            end else if (a > 58'sd65535) begin
                r4_next.alpha = 16'hFFFF;
            end else begin
                r4_next.alpha = a[15:0];
            end
        end
        g = 60'(64'sd1 <<< FRAC_BITS) + (grow3_reg >>> FRAC_BITS);
        gzero4_next = g <= 0;
        g4_next     = (g > 60'sd4294967296) ? 33'h1_0000_0000 : g[32:0];
    end

    // Stage 5: size and sway products.
    always_comb begin
        logic signed [16:0] dt_s;
        dt_s        = $signed({1'b0, r4_reg.dt});
        r5_next     = r4_reg;
        sprod5_next = 64'(cfg.base) * 64'(g4_reg);
        sndt5_next  = 49'(sin4) * 49'(dt_s);
        csdt5_next  = 49'(cos4) * 49'(dt_s);
    end

    // Stage 6: saturate size, add snow sway.
    always_comb begin
        logic [47:0] s;
        s       = sprod5_reg[63:16];
        r6_next = r5_reg;
        if (r5_reg.alive && cfg.kind == KIND_TRAIL) begin
            if (gzero5_reg) begin
                r6_next.size = '0;
            end else if (s > 48'h7FFF_FFFF) begin
                r6_next.size = 31'h7FFF_FFFF;
            end else begin
                r6_next.size = s[30:0];
            end
        end
        if (r5_reg.alive && cfg.kind == KIND_SNOW) begin
            r6_next.vx = r5_reg.vx + 32'(sndt5_reg >>> 31);
            r6_next.vz = r5_reg.vz + 32'(csdt5_reg >>> 31);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg      <= r1_next;
            gdt1_reg    <= gdt1_next;
            vxdt1_reg   <= vxdt1_next;
            vzdt1_reg   <= vzdt1_next;
            r2_reg      <= r2_next;
            rp2_reg     <= rp2_next;
            ph3_2_reg   <= ph3_2_next;
            ph25_2_reg  <= ph25_2_next;
            r3_reg      <= r3_next;
            vydt3_reg   <= vydt3_next;
            ratio3_reg  <= ratio3_next;
            apr3_reg    <= apr3_next;
            grow3_reg   <= grow3_next;
            r4_reg      <= r4_next;
            g4_reg      <= g4_next;
            gzero4_reg  <= gzero4_next;
            r5_reg      <= r5_next;
            sprod5_reg  <= sprod5_next;
            gzero5_reg  <= gzero4_reg;
            sndt5_reg   <= sndt5_next;
            csdt5_reg   <= csdt5_next;
            r6_reg      <= r6_next;
        end
    end

    assign m_new_pos_x = r6_reg.px;
    assign m_new_pos_y = r6_reg.py;
    assign m_new_pos_z = r6_reg.pz;
    assign m_new_vel_x = r6_reg.vx;
    assign m_new_vel_y = r6_reg.vy;
    assign m_new_vel_z = r6_reg.vz;
    assign m_new_life  = r6_reg.life;
    assign m_new_size  = r6_reg.size;
    assign m_new_alpha = r6_reg.alpha;
    assign m_was_alive = r6_reg.alive;

endmodule

`default_nettype wire

[design/pel_checker.sv]
// ----------------------------------------------------------------------------
// pel_checker
// Port-level checks on the particle update, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_euler_update_macros.svh"

module pel_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_new_pos_x,
    input wire logic signed [31:0] m_new_life,
    input wire logic               m_was_alive
);

    `PEL_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_new_pos_x))
    `PEL_ASSERT(a_ready_follows, s_ready == (!m_valid || m_ready))
    `PEL_ASSERT_OUT(a_dead_life, m_was_alive || (m_new_life <= 0))
    `PEL_ASSERT_OUT(a_live_life, !m_was_alive || (m_new_life > -32'sd65536))

endmodule

bind particle_euler_update pel_checker u_pel_checker (.*);

`default_nettype wire

[verif/tb_particle_euler_update.sv]
// ----------------------------------------------------------------------------
// tb_particle_euler_update
// Self-checking bench for the particle Euler step pipeline.
// ----------------------------------------------------------------------------
// Particle items go in through a valid/ready channel with random gaps. A local
// fixed point model works out each advanced particle as the item is accepted
// and queues it. Results are compared field by field, in order, as they leave.
// The run walks a short directed table under the reset settings, then random
// phases, each under new register settings. The settings include every particle
// kind, the extremes of gravity, reciprocal and base size, and a zero
// reciprocal. In one phase the receiver holds off long enough to back the
// pipeline up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_particle_euler_update;
    timeunit 1ns;
    timeprecision 1ps;

    import pel_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 92;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = REG_KIND;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [31:0] s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic signed [31:0] s_life_left = '0;
    logic [30:0]        s_size_now = '0;
    logic [15:0]        s_alpha_now = '0, s_step_time = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_new_pos_x, m_new_pos_y, m_new_pos_z;
    logic signed [31:0] m_new_vel_x, m_new_vel_y, m_new_vel_z;
    logic signed [31:0] m_new_life;
    logic [30:0]        m_new_size;
    logic [15:0]        m_new_alpha;
    logic               m_was_alive;

    particle_euler_update u_top (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Local copy of the registers and of the quarter-wave sine table
    logic [1:0]         kind_q  = KIND_TRAIL;
    logic signed [31:0] grav_q  = -32'sd19661;
    logic [24:0]        recip_q = 25'd13107;
    logic [30:0]        base_q  = 31'd983040;
    longint             quarter_sine[0:TABLE_DEPTH];

    rec_t advanced_q[$];
    int   mismatches = 0;
    bit   calm = 1'b0;       // no idling on either side while set
    bit   long_hold = 1'b0;  // receiver holds off once for a long hold, then clears this
    int   quiet_cycles = 0;

    function automatic longint sway_sine(logic [31:0] ph);
        int     idx;
        longint v;
        idx = ph[29:22];
        v   = ph[30] ? quarter_sine[TABLE_DEPTH - idx] : quarter_sine[idx];
        return ph[31] ? -v : v;
    endfunction

    // One Euler step under the current register copy
    function automatic rec_t euler_step(rec_t p);
        rec_t        r;
        longint      dt, life, vy, ratio, a, g, sn, cs;
        logic [63:0] t, sz;
        r = p;
        r.dt = '0;
        r.alive = 1'b0;
        if (p.life > 0) begin
            r.alive = 1'b1;
            dt    = p.dt;
            life  = longint'(p.life) - dt;
            vy    = longint'(p.vy) + ((longint'(grav_q) * dt) >>> 16);
            r.vy  = vy[31:0];
            r.px  = p.px + 32'((longint'(p.vx) * dt) >>> 16);
            r.py  = p.py + 32'((longint'(r.vy) * dt) >>> 16);
            r.pz  = p.pz + 32'((longint'(p.vz) * dt) >>> 16);
            r.life = life[31:0];
            ratio = (life * longint'({39'd0, recip_q})) >>> 16;
            if (kind_q == KIND_TRAIL) a = ratio >>> 1;
            else a = (ratio * 39322) >>> 16;
            if (a < 0) a = 0;
            if (a > 65535) a = 65535;
            r.alpha = a[15:0];
            if (kind_q == KIND_TRAIL) begin
                g = 65536 + (((65536 - ratio) * 52429) >>> 16);
                if (g <= 0) begin
                    r.size = '0;
                end else begin
                    if (g > (64'sd1 <<< 32)) g = 64'sd1 <<< 32;
                    sz = ({33'd0, base_q} * g) >> 16;
                    r.size = (sz > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sz[30:0];
                end
            end
            if (kind_q == KIND_SNOW) begin
                t    = (life * 2050695827) >>> 16;
                sn   = sway_sine(t[31:0]);
                t    = (life * 1708913189) >>> 16;
                cs   = sway_sine(t[31:0] + 32'h4000_0000);
                r.vx = p.vx + 32'((sn * dt) >>> 31);
                r.vz = p.vz + 32'((cs * dt) >>> 31);
            end
        end
        return r;
    endfunction

    function automatic rec_t particle(logic [31:0] px, py, pz, vx, vy, vz, life,
                                      logic [30:0] size, logic [15:0] alpha, dt);
        rec_t p;
        p = '{px, py, pz, vx, vy, vz, life, size, alpha, dt, 1'b0};
        return p;
    endfunction

    function automatic rec_t random_particle();
        rec_t p;
        int   pick;
        p = particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     0, 31'($urandom), 16'($urandom), 16'($urandom_range(0, 65535)));
        pick = $urandom_range(0, 9);
        if (pick <= 5) p.life = $urandom_range(1, 32'h0008_0000);
        else if (pick == 6) p.life = $urandom_range(1, 65535);
        else if (pick == 7) p.life = -$urandom_range(0, 2000);
        else p.life = $urandom;
        // keep some velocities modest so positions move sensibly
        if ($urandom_range(0, 1)) begin
            p.vx = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            p.vy = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            p.vz = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        end
        return p;
    endfunction

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Offer one particle item, predict its result on acceptance
    task automatic send_particle(rec_t p);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_pos_x <= p.px; s_pos_y <= p.py; s_pos_z <= p.pz;
        s_vel_x <= p.vx; s_vel_y <= p.vy; s_vel_z <= p.vz;
        s_life_left <= p.life; s_size_now <= p.size;
        s_alpha_now <= p.alpha; s_step_time <= p.dt;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        advanced_q.push_back(euler_step(p));
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_KIND:    kind_q  = value[1:0];
            REG_GRAVITY: grav_q  = value;
            REG_RECIP:   recip_q = value[24:0];
            default:     base_q  = value[30:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Hold until every queued result has left, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        while (advanced_q.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // Receiver: random back-pressure per item, plus one long hold-off
    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold = 1'b0;
            end
            stall = idle_draw();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && !long_hold);
            @(negedge aclk);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin
        rec_t   want;
        longint got_f[10], want_f[10];
        string  names[10];
        if (aresetn && m_valid && m_ready) begin
            if (advanced_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
            end else begin
                want = advanced_q.pop_front();
                names  = '{"new_pos_x", "new_pos_y", "new_pos_z", "new_vel_x", "new_vel_y",
                           "new_vel_z", "new_life", "new_size", "new_alpha", "was_alive"};
                want_f = '{want.px, want.py, want.pz, want.vx, want.vy, want.vz,
                           want.life, want.size, want.alpha, want.alive};
                got_f  = '{m_new_pos_x, m_new_pos_y, m_new_pos_z, m_new_vel_x, m_new_vel_y,
                           m_new_vel_z, m_new_life, m_new_size, m_new_alpha, m_was_alive};
                for (int i = 0; i < 10; i++) begin
                    if (got_f[i] !== want_f[i]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%s: expected %0h, got %0h at %0t",
                                     names[i], want_f[i], got_f[i], $realtime);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("particle_euler_update: mismatch");
            $finish;
        end
    end

    typedef struct {
        rec_t stim;
        bit   typed;
        rec_t result;
    } row_t;

    logic [31:0] ph_kind[N_PHASES]  = '{0, 1, 2, 3, 0, 2, 0, 2};
    logic [31:0] ph_recip[N_PHASES] = '{13107, 0, 16777216, 1, 0, 5000, 16777216, 32'h1FF_FFFF};
    logic [31:0] ph_base[N_PHASES]  = '{983040, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 983040};

    initial begin
        row_t        rows[$];
        row_t        row;
        rec_t        p;
        longint      x, term, acc;
        logic [31:0] grav;

        // quarter-wave table, Taylor series truncating at each step
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            x = 64'sd1686629713 * i / TABLE_DEPTH;
            term = x;
            acc = x;
            for (int k = 1; k <= 8; k++) begin
                term = term * x / (64'sd1 <<< 30);
                term = term * x / (64'sd1 <<< 30);
                term = -(term / ((2 * k) * (2 * k + 1)));
                acc += term;
            end
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
            quarter_sine[i] = acc;
        end

        // Directed rows under the reset settings (trail)
        p = particle(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
        row = '{p, 1'b1, p};
        rows.push_back(row);                       // dead at zero life: pass through
        p = particle(0, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0);
        row = '{p, 1'b1, p};
        rows.push_back(row);                       // most negative life: dead
        p = particle(0, 0, 0, 0, 0, 0, 32'h0001_0000, 7, 9, 0);
        row = '{p, 1'b1, particle(0, 0, 0, 0, 0, 0, 32'h0001_0000, 1612185, 6553, 0)};
        row.result.alive = 1'b1;
        rows.push_back(row);                       // live with a zero step
        foreach (rows[i]) rows[i].result.dt = '0;
        rows.push_back('{particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                  16'hFFFF, 16'hFFFF), 1'b0, p});   // largest everything
        rows.push_back('{particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 1, 0, 0, 16'hFFFF), 1'b0, p});
        rows.push_back('{particle(0, 0, 0, 0, 0, 0, 1, 0, 0, 1), 1'b0, p});  // life hits zero
        rows.push_back('{particle(5, 5, 5, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                                  32'h0000_4000, 100, 200, 16'h8000), 1'b0, p});
        rows.push_back('{particle(0, 0, 0, 0, 0, 0, 32'h0050_0000, 3, 4, 16'h1000), 1'b0, p});
        rows.push_back('{particle(0, 0, 0, 0, 0, 0, 32'h0010_0000, 3, 4, 16'h0001), 1'b0, p});
        repeat (8) rows.push_back('{random_particle(), 1'b0, p});

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            send_particle(rows[i].stim);
            // overwrite the prediction where the row carries its own result
            if (rows[i].typed) advanced_q[advanced_q.size() - 1] = rows[i].result;
        end
        drain();

        // Random phases, each under its own register settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            grav = (ph == 2) ? 32'h7FFF_FFFF : (ph == 3) ? 32'h8000_0000 :
                   (ph == 0 || ph == 7) ? -32'sd19661 : $urandom;
            write_reg(REG_KIND, ph_kind[ph]);
            write_reg(REG_GRAVITY, grav);
            write_reg(REG_RECIP, (ph == 1) ? $urandom_range(1, 16777216) : ph_recip[ph]);
            write_reg(REG_BASE, (ph == 5 || ph == 6) ? ($urandom & 32'h7FFF_FFFF)
                                                     : ph_base[ph]);
            calm = (ph == 4);
            if (ph == 2) long_hold = 1'b1;   // back up the pipe with items still coming
            repeat (PHASE_ITEMS) send_particle(random_particle());
            calm = 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("particle_euler_update: match");
        else
            $display("particle_euler_update: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
